@@ rtl/wrba_pkg.sv @@
// wrba_pkg: shared constants and types for the weighted rigid blend accumulator
// no dependencies
`timescale 1ns / 1ps
package wrba_pkg;
	localparam int MAX_PATCHES = 256;
	localparam int MAX_VERTICES = 4096;
	localparam int WORDS_PER_TRANSFORM = 12;
	localparam int ROT_WORDS = 9;
	localparam int TAB_DEPTH = MAX_PATCHES * WORDS_PER_TRANSFORM;
	localparam int TAB_AW = $clog2(TAB_DEPTH);
	localparam int VTX_AW = $clog2(MAX_VERTICES);

	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_ACC  = 1'b1
	} cmd_t;

	// product request into the shared multiplier
	typedef struct packed {
		logic               vld;
		logic signed [32:0] a;
		logic signed [32:0] b;
	} mul_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage

@@ rtl/wrba_mul.sv @@
// wrba_mul: shared registered 33x33 signed multiplier
// depends on wrba_pkg
`timescale 1ns / 1ps
module wrba_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  wrba_pkg::mul_req_t  req,
	output logic                vld,
	output logic signed [65:0]  prod
);
	import wrba_pkg::*;

	// one product per cycle, registered: the result comes in the cycle after the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else begin
			vld <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod <= $signed(req.a) * $signed(req.b);
	end
endmodule

@@ rtl/weighted_rigid_blend_accumulator.sv @@
// weighted_rigid_blend_accumulator: top level, sequencer, transform and accumulator memories
// depends on wrba_pkg and wrba_mul
`timescale 1ns / 1ps
// Usage: present an item with start high while busy is low; it is taken at that edge.
// command 0 writes one transform word into the table (no result).
// command 1 accumulates weight*(R*offset+t) into the vertex accumulator and
// returns the new x/y/z sum on pos_x/pos_y/pos_z with done high for one cycle.
// An accumulate runs row by row from the start edge to the edge that takes the
// result: per row, three rotation words and the translation are read from the
// table, three rotation products and one weight product pass the one shared
// multiplier, and the accumulator memory is written once; then ST_DONE raises
// done. busy is high from the start edge until done rises, so the next item can
// be taken at the edge that takes the result. No new item is taken while an
// accumulate is in progress; loads are taken one per cycle while busy is low.
// Out-of-range transform or vertex on an accumulate gives no result.
// Reset clears the sequencer only; memories hold no valid bits and are
// undefined until written. The receiver cannot stall: done is a one-cycle strobe.
module weighted_rigid_blend_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [0:0]          command,
	input  logic [7:0]          transform_index,
	input  logic [3:0]          word_index,
	input  logic signed [31:0]  word_value,
	input  logic [11:0]         vertex_index,
	input  logic                first_contribution,
	input  logic [16:0]         weight,
	input  logic signed [31:0]  offset_x,
	input  logic signed [31:0]  offset_y,
	input  logic signed [31:0]  offset_z,
	output logic                done,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [31:0]  pos_z
);
	import wrba_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_WMUL = 7'b0001000,
		ST_WRES = 7'b0010000,
		ST_ACC  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [1:0]          row_q;
	logic [2:0]          col_q;   // 0..4 words read for this row
	logic [2:0]          prd_q;   // products returned for this row
	logic [TAB_AW-1:0]   base_q;
	logic [VTX_AW-1:0]   vtx_q;
	logic                first_q;
	logic [16:0]         weight_q;
	logic signed [31:0]  off_q [3];
	logic signed [65:0]  sum_q;
	logic signed [31:0]  res_q [3];

	// memories
	logic [31:0] tab_mem [TAB_DEPTH];
	logic [31:0] acc_mem [3][MAX_VERTICES];
	logic signed [31:0] tab_rd_q;
	logic               tab_rd_vld_q;
	logic [1:0]         tab_rd_col_q;
	logic signed [31:0] acc_rd_q;

	mul_req_t           req;
	logic               mvld;
	logic signed [65:0] prod;

	wrba_mul u_mul (.clk(clk), .arst_n(arst_n), .req(req), .vld(mvld), .prod(prod));

	logic accept, ok_acc;
	assign accept = start && (state_q == ST_IDLE);
	assign ok_acc = (32'(transform_index) < MAX_PATCHES) && (32'(vertex_index) < MAX_VERTICES);
	assign busy = (state_q != ST_IDLE);

	// table address for the current read
	logic [TAB_AW-1:0] rd_addr;
	always_comb begin
		if (col_q == 3'd3) begin
			rd_addr = base_q + TAB_AW'(ROT_WORDS) + TAB_AW'(row_q);
		end else begin
			rd_addr = base_q + TAB_AW'(row_q) * TAB_AW'(3) + TAB_AW'(col_q);
		end
	end

	// table port: load writes, sequencer reads
	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD && 32'(transform_index) < MAX_PATCHES
				&& 32'(word_index) < WORDS_PER_TRANSFORM) begin
			tab_mem[TAB_AW'(transform_index) * TAB_AW'(WORDS_PER_TRANSFORM)
				+ TAB_AW'(word_index)] <= word_value;
		end
		tab_rd_q <= tab_mem[rd_addr];
		tab_rd_col_q <= col_q[1:0];
		acc_rd_q <= acc_mem[row_q][vtx_q];
		if (state_q == ST_ACC) begin
			acc_mem[row_q][vtx_q] <= res_q[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_rd_vld_q <= 1'b0;
		end else begin
			tab_rd_vld_q <= (state_q == ST_RD) && (col_q < 3'd3);
		end
	end

	// multiplier operand selection
	always_comb begin
		req.vld = 1'b0;
		req.a = 33'(tab_rd_q);
		req.b = 33'(off_q[tab_rd_col_q]);
		if (tab_rd_vld_q) begin
			req.vld = 1'b1;
		end else if (state_q == ST_WMUL && prd_q == 3'd3) begin
			req.vld = 1'b1;
			req.a = 33'(sat32(sum_q));
			req.b = $signed({16'd0, weight_q});
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			prd_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_ACC && ok_acc) begin
						state_q <= ST_RD;
						row_q <= '0;
						col_q <= '0;
						prd_q <= '0;
					end
				end
				ST_RD: begin
					col_q <= col_q + 3'd1;
					if (mvld) prd_q <= prd_q + 3'd1;
					if (col_q == 3'd3) state_q <= ST_MUL;
				end
				ST_MUL: begin
					// last rotation product and the translation word arrive now
					if (mvld) prd_q <= prd_q + 3'd1;
					state_q <= ST_WMUL;
				end
				ST_WMUL: begin
					state_q <= ST_WRES;
				end
				ST_WRES: begin
					// weight product returns
					if (mvld) prd_q <= prd_q + 3'd1;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					prd_q <= '0;
					col_q <= '0;
					if (row_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						row_q <= row_q + 2'd1;
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, row sum and row result
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= TAB_AW'(transform_index) * TAB_AW'(WORDS_PER_TRANSFORM);
			vtx_q <= vertex_index[VTX_AW-1:0];
			first_q <= first_contribution;
			weight_q <= weight;
			off_q[0] <= offset_x;
			off_q[1] <= offset_y;
			off_q[2] <= offset_z;
		end
		if (state_q == ST_RD && col_q == 3'd0) begin
			sum_q <= '0;
		end else if (state_q == ST_RD && mvld) begin
			sum_q <= sum_q + (prod >>> 16);
		end else if (state_q == ST_MUL) begin
			sum_q <= sum_q + 66'(tab_rd_q) + (prod >>> 16);
		end
		if (state_q == ST_WRES) begin
			res_q[row_q] <= first_q ? sat32(prod >>> 16)
				: sat32(66'(acc_rd_q) + (prod >>> 16));
		end
	end

	assign pos_x = res_q[0];
	assign pos_y = res_q[1];
	assign pos_z = res_q[2];

	a_done_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DONE) else $error("done without sequence");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("accept while busy");
	a_prd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prd_q <= 3'd4) else $error("product count overflow");
	a_wmul_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WMUL) |-> prd_q == 3'd3) else $error("row sum incomplete");
endmodule

@@ test/tb_blend_checker.sv @@
// tb_blend_checker: watches accepted commands and done strobes, predicts vertex sums
// depends on wrba_pkg
`timescale 1ns / 1ps
module tb_blend_checker
	import wrba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [0:0]         command,
	input  logic [7:0]         transform_index,
	input  logic [3:0]         word_index,
	input  logic signed [31:0] word_value,
	input  logic [11:0]        vertex_index,
	input  logic               first_contribution,
	input  logic [16:0]        weight,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic               done,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output int                 fail_count,
	output int                 pending_sums
);
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	logic signed [31:0] xform_words [TAB_DEPTH];
	logic signed [31:0] sum_mem [3][MAX_VERTICES];
	vec_t expected_sums [$];

	assign pending_sums = expected_sums.size();

	function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
		return v >>> 16;
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	// blend one contribution into the vertex sums and queue the new position
	task automatic blend_vertex();
		logic signed [63:0] off [3];
		logic signed [63:0] p, q, n;
		int base;
		vec_t res;
		off[0] = offset_x;
		off[1] = offset_y;
		off[2] = offset_z;
		base = transform_index * WORDS_PER_TRANSFORM;
		for (int r = 0; r < 3; r++) begin
			p = 0;
			for (int c = 0; c < 3; c++)
				p += floor16(64'(xform_words[base + r*3 + c]) * off[c]);
			p = clamp32(p + 64'(xform_words[base + ROT_WORDS + r]));
			q = floor16(p * $signed({47'd0, weight}));
			n = first_contribution ? clamp32(q) :
				clamp32(64'(sum_mem[r][vertex_index]) + q);
			sum_mem[r][vertex_index] = n[31:0];
			if (r == 0) res.x = n[31:0];
			else if (r == 1) res.y = n[31:0];
			else res.z = n[31:0];
		end
		expected_sums.push_back(res);
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin
		vec_t e;
		if (arst_n) begin
			// command transfer
			if (start && !busy) begin
				if (command == CMD_LOAD) begin
					if (transform_index < MAX_PATCHES && word_index < WORDS_PER_TRANSFORM)
						xform_words[transform_index*WORDS_PER_TRANSFORM + word_index]
							= word_value;
				end else if (transform_index < MAX_PATCHES && vertex_index < MAX_VERTICES)
					blend_vertex();
			end
			// result transfer
			if (done) begin
				if (expected_sums.size() == 0) begin
					$display("%0t unexpected result", $time);
					fail_count++;
				end else begin
					e = expected_sums.pop_front();
					if (pos_x !== e.x) report_mismatch("pos_x", pos_x, e.x);
					if (pos_y !== e.y) report_mismatch("pos_y", pos_y, e.y);
					if (pos_z !== e.z) report_mismatch("pos_z", pos_z, e.z);
				end
			end
		end
	end
endmodule

@@ test/tb_top.sv @@
// tb_top: clock, reset and command stimulus for the blend accumulator, final verdict
// depends on wrba_pkg, weighted_rigid_blend_accumulator and tb_blend_checker
`timescale 1ns / 1ps
module tb_top;
	import wrba_pkg::*;

	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 64;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic [0:0] command = CMD_LOAD;
	logic [7:0] transform_index = 0;
	logic [3:0] word_index = 0;
	logic signed [31:0] word_value = 0;
	logic [11:0] vertex_index = 0;
	logic first_contribution = 0;
	logic [16:0] weight = 0;
	logic signed [31:0] offset_x = 0, offset_y = 0, offset_z = 0;
	logic signed [31:0] pos_x, pos_y, pos_z;
	int fail_count, pending_sums;

	// transforms and vertices fully written so far
	bit loaded_xform [MAX_PATCHES];
	bit seeded_vertex [MAX_VERTICES];
	int burst_left = 0;
	int sent_items = 0;

	weighted_rigid_blend_accumulator dut (.*);
	tb_blend_checker checker_i (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("weighted_rigid_blend_accumulator regression: fail");
		$finish;
	end

	function automatic logic signed [31:0] edgy32();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh00010000;
			3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	// hand one command over, with random gaps between bursts
	task automatic send(input cmd_t cmd, input int ti, input int wi,
			input logic signed [31:0] wv, input int vi, input bit first,
			input int w, input logic signed [31:0] ox, input logic signed [31:0] oy,
			input logic signed [31:0] oz);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				start <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		sent_items++;
		command <= cmd;
		transform_index <= 8'(ti);
		word_index <= 4'(wi);
		word_value <= wv;
		vertex_index <= 12'(vi);
		first_contribution <= first;
		weight <= 17'(w);
		offset_x <= ox;
		offset_y <= oy;
		offset_z <= oz;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_xform(input int ti, input bit identity);
		for (int k = 0; k < WORDS_PER_TRANSFORM; k++)
			send(CMD_LOAD, ti, k, identity ? ((k % 4 == 0 && k < 9) ? 32'sh10000 : 0)
				: edgy32(), $urandom, 1'($urandom), $urandom, $urandom, $urandom,
				$urandom);
		loaded_xform[ti] = 1;
	endtask

	task automatic blend(input int ti, input int vi, input int w,
			input logic signed [31:0] ox, input logic signed [31:0] oy,
			input logic signed [31:0] oz);
		bit first;
		first = !seeded_vertex[vi] || $urandom_range(0, 7) == 0;
		send(CMD_ACC, ti, $urandom, $urandom, vi, first, w, ox, oy, oz);
		seeded_vertex[vi] = 1;
	endtask

	initial begin
		int ti, vi;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: identity and extreme transforms, weight and offset limits
		load_xform(0, 1);
		load_xform(255, 0);
		blend(0, 0, 65536, 32'sh7fffffff, 32'sh80000000, 0);
		blend(0, 0, 0, 1, 1, 1);
		blend(255, 4095, 131071, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		blend(255, 4095, 131071, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		blend(255, 4095, 1, -1, -1, -1);
		// ignored loads: word index out of range
		send(CMD_LOAD, 0, 12, 32'sh7fffffff, 0, 1'b0, 0, 0, 0, 0);
		send(CMD_LOAD, 0, 15, 32'sh80000000, 0, 1'b0, 0, 0, 0, 0);
		blend(0, 1, 65537, -65536, 65536, 12345);

		// random: mostly blends over a small set of loaded transforms, some reloads
		while (sent_items < RANDOM_ITEMS) begin
			ti = $urandom_range(0, 15);
			if (!loaded_xform[ti] || $urandom_range(0, 15) == 0)
				load_xform(ti, $urandom_range(0, 3) == 0);
			else if ($urandom_range(0, 31) == 0)
				send(CMD_LOAD, ti, $urandom_range(12, 15), $urandom, 0, 1'b0, 0, 0, 0, 0);
			else if ($urandom_range(0, 15) == 0)
				send(CMD_LOAD, ti, $urandom_range(0, 11), edgy32(), $urandom,
					1'($urandom), $urandom, $urandom, $urandom, $urandom);
			else begin
				vi = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
					: $urandom_range(0, 31);
				blend(ti, vi, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
					: $urandom_range(0, 65536), edgy32(), edgy32(), edgy32());
			end
		end
		start <= 0;

		while (pending_sums != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("weighted_rigid_blend_accumulator regression: pass");
		else
			$display("weighted_rigid_blend_accumulator regression: fail");
		$finish;
	end
endmodule
